>>> rtl/upc_pkg.sv
// Types, codes and character helpers for the URL percent codec.
// Self-contained; used by url_percent_codec_core.
package upc_pkg;

    // Coding modes held in the mode register
    localparam logic [2:0] MODE_FORM_ENC = 3'd0;
    localparam logic [2:0] MODE_URI_ENC  = 3'd1;
    localparam logic [2:0] MODE_COMP_ENC = 3'd2;
    localparam logic [2:0] MODE_FORM_DEC = 3'd3;
    localparam logic [2:0] MODE_DEC      = 3'd4;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TILDE   = 8'h7E;
    localparam logic [7:0] CH_UNDER   = 8'h5F;

    // Escape progress of the decoder
    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_PCT   = 3'b010,
        PH_DIGIT = 3'b100
    } upc_phase_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } upc_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       string_done;
    } upc_out_t;

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        if (c >= "0" && c <= "9")
            v = c - 8'h30;
        else if (c >= "A" && c <= "F")
            v = c - 8'h37;
        else if (c >= "a" && c <= "f")
            v = c - 8'h57;
        return v[3:0];
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return (n < 4'd10) ? (8'h30 + {4'd0, n}) : (8'h37 + {4'd0, n});
    endfunction

    // Characters that pass unescaped in each encode mode
    function automatic logic is_kept(input logic [2:0] m, input logic [7:0] c);
        logic k;
        k = is_alnum(c) || c == "-" || c == "." || c == CH_UNDER;
        if (m == MODE_URI_ENC)
        begin
            k = k || c == "&" || c == "!" || c == "#" || c == "$" || c == "'"
                  || c == "(" || c == ")" || c == CH_PLUS || c == "," || c == "*"
                  || c == "/" || c == "@" || c == "?" || c == "=" || c == ";"
                  || c == ":" || c == CH_TILDE;
        end
        else if (m == MODE_COMP_ENC)
        begin
            k = k || c == "!" || c == "(" || c == ")" || c == "*" || c == "'"
                  || c == CH_TILDE;
        end
        return k;
    endfunction

endpackage

>>> rtl/url_percent_codec_core.sv
// URL percent codec: top level with coding logic and result buffer.
// Depends on upc_pkg for item types, mode codes and character helpers.

// The block percent-encodes (form, URI or component rules) or decodes (form or
// plain) a byte stream, selected by the mode register; writing mode drops any
// pending escape. Each input item yields zero to three output items, coded in
// one pass into a three-byte result buffer that then drains one byte per cycle
// while code_ready is high, so the single output byte port sets the pace. A new
// item is taken only once the buffer is empty or its last byte is being taken,
// so the next item is taken in the same cycle that the buffer's last byte is
// taken and there are no gap cycles.
module url_percent_codec_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              mode_we,
    input  logic [2:0]        mode_wdata,
    input  logic              byte_valid,
    output logic              byte_ready,
    input  upc_pkg::upc_in_t  byte_item,
    output logic              code_valid,
    input  logic              code_ready,
    output upc_pkg::upc_out_t code_item
);

    logic [2:0]          mode_reg;
    upc_pkg::upc_phase_t phase_reg, phase_next;
    logic [7:0]          held_reg, held_next;

    logic [7:0] res_reg [3];
    logic [7:0] res_next [3];
    logic [1:0] cnt_reg, cnt_next;
    logic [1:0] idx_reg;
    logic       eos_reg;

    logic in_fire, out_fire, last_out;

    assign code_valid = (cnt_reg != 2'd0);
    assign last_out   = (idx_reg == cnt_reg - 2'd1);
    assign out_fire   = code_valid && code_ready;
    // take a new item once the buffer is empty or its last byte leaves now
    assign byte_ready = !code_valid || (code_ready && last_out);
    assign in_fire    = byte_valid && byte_ready;

    assign code_item.out_byte    = res_reg[idx_reg];
    assign code_item.last_of_run = last_out;
    assign code_item.string_done = last_out && eos_reg;

    // Code one item: append up to three bytes and advance the escape state
    always_comb
    begin
        logic [7:0] b;
        logic       eos;
        logic       form;
        logic       fresh;
        b          = byte_item.in_byte;
        eos        = byte_item.end_of_string;
        form       = (mode_reg == upc_pkg::MODE_FORM_DEC);
        fresh      = 1'b0;
        cnt_next   = 2'd0;
        phase_next = phase_reg;
        held_next  = held_reg;
        for (int i = 0; i < 3; i++)
            res_next[i] = 8'd0;

        if (mode_reg < upc_pkg::MODE_FORM_DEC)
        begin
            if (mode_reg == upc_pkg::MODE_FORM_ENC && b == upc_pkg::CH_SPACE)
            begin
                res_next[0] = upc_pkg::CH_PLUS;
                cnt_next    = 2'd1;
            end
            else if (upc_pkg::is_kept(mode_reg, b))
            begin
                res_next[0] = b;
                cnt_next    = 2'd1;
            end
            else
            begin
                res_next[0] = upc_pkg::CH_PERCENT;
                res_next[1] = upc_pkg::hex_char(b[7:4]);
                res_next[2] = upc_pkg::hex_char(b[3:0]);
                cnt_next    = 2'd3;
            end
            if (eos)
            begin
                phase_next = upc_pkg::PH_IDLE;
                held_next  = 8'd0;
            end
        end
        else
        begin
            case (phase_reg)
                upc_pkg::PH_PCT:
                begin
                    if (upc_pkg::is_hex(b))
                    begin
                        held_next  = b;
                        phase_next = upc_pkg::PH_DIGIT;
                    end
                    else
                    begin
                        // broken escape: emit the held percent literally
                        res_next[0] = upc_pkg::CH_PERCENT;
                        cnt_next    = 2'd1;
                        phase_next  = upc_pkg::PH_IDLE;
                        fresh       = 1'b1;
                    end
                end
                upc_pkg::PH_DIGIT:
                begin
                    if (upc_pkg::is_hex(b))
                    begin
                        res_next[0] = {upc_pkg::hex_val(held_reg), upc_pkg::hex_val(b)};
                        cnt_next    = 2'd1;
                        phase_next  = upc_pkg::PH_IDLE;
                        held_next   = 8'd0;
                    end
                    else
                    begin
                        res_next[0] = upc_pkg::CH_PERCENT;
                        res_next[1] = held_reg;
                        cnt_next    = 2'd2;
                        phase_next  = upc_pkg::PH_IDLE;
                        held_next   = 8'd0;
                        fresh       = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = upc_pkg::PH_IDLE;
                    fresh      = 1'b1;
                end
            endcase

            // handle the current byte from idle
            if (fresh)
            begin
                if (b == upc_pkg::CH_PERCENT)
                    phase_next = upc_pkg::PH_PCT;
                else
                begin
                    res_next[cnt_next] = (form && b == upc_pkg::CH_PLUS) ?
                                         upc_pkg::CH_SPACE : b;
                    cnt_next = cnt_next + 2'd1;
                end
            end

            // flush a pending escape at end of string
            if (eos)
            begin
                if (phase_next != upc_pkg::PH_IDLE)
                begin
                    res_next[cnt_next] = upc_pkg::CH_PERCENT;
                    cnt_next = cnt_next + 2'd1;
                end
                if (phase_next == upc_pkg::PH_DIGIT)
                begin
                    res_next[cnt_next] = held_next;
                    cnt_next = cnt_next + 2'd1;
                end
                phase_next = upc_pkg::PH_IDLE;
                held_next  = 8'd0;
            end
        end
    end

    // Mode register and escape state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= upc_pkg::MODE_FORM_ENC;
            phase_reg <= upc_pkg::PH_IDLE;
            held_reg  <= 8'd0;
        end
        else if (mode_we)
        begin
            mode_reg  <= mode_wdata;
            phase_reg <= upc_pkg::PH_IDLE;
            held_reg  <= 8'd0;
        end
        else if (in_fire)
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

    // Result buffer: load on a new item, otherwise advance through the bytes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            idx_reg <= 2'd0;
            eos_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            cnt_reg <= cnt_next;
            idx_reg <= 2'd0;
            eos_reg <= byte_item.end_of_string;
        end
        else if (out_fire)
        begin
            if (last_out)
                cnt_reg <= 2'd0;
            else
                idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            for (int i = 0; i < 3; i++)
                res_reg[i] <= res_next[i];
        end
    end

    // the read pointer never passes the loaded count
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        code_valid |-> (idx_reg < cnt_reg))
        else $error("result read pointer beyond loaded count");

    // an end-of-string item always gives at least one result
    a_eos_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && byte_item.end_of_string) |=> code_valid)
        else $error("end of string gave no result");

    // end of string leaves no pending escape
    a_eos_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && byte_item.end_of_string) |=> (phase_reg == upc_pkg::PH_IDLE))
        else $error("escape still pending after end of string");

    // a stalled last byte keeps the input side closed
    a_hold_block: assert property (@(posedge clk) disable iff (!rst_n)
        (code_valid && !code_ready) |-> !byte_ready)
        else $error("item taken while result buffer is stalled");

endmodule

>>> verif/url_percent_codec_core_tb.sv
// Self-checking testbench for url_percent_codec_core: a clocked driver and monitor
// check every coded output item against an in-bench prediction of the codec.
// Depends on upc_pkg (item structs, mode codes, character constants) and the core.
module url_percent_codec_core_tb;

    localparam int CLK_PERIOD = 12;

    logic     clk        = 1'b0;
    logic     rst_n      = 1'b0;
    logic     mode_we    = 1'b0;
    logic [2:0] mode_wdata = upc_pkg::MODE_FORM_ENC;
    logic     byte_valid = 1'b0;
    logic     byte_ready;
    upc_pkg::upc_in_t  byte_item  = '0;
    logic     code_valid;
    logic     code_ready = 1'b0;
    upc_pkg::upc_out_t code_item;

    // Items waiting to be offered, and coded items still owed by the block
    upc_pkg::upc_in_t  byte_feed[$];
    upc_pkg::upc_out_t due_codes[$];

    // Predicted codec state; mode changes only while the block is idle
    logic [2:0]           cur_mode  = upc_pkg::MODE_FORM_ENC;
    upc_pkg::upc_phase_t  dec_phase = upc_pkg::PH_IDLE;
    logic [7:0]           held_char = 8'd0;
    logic [7:0]           burst[$];

    // Traffic shaping: steady turns idling off, hold_request asks for one long stall
    logic steady       = 1'b0;
    logic hold_request = 1'b0;
    logic hold_taken   = 1'b0;
    int   hold_left    = 0;

    int bytes_taken = 0;
    int codes_seen  = 0;
    int mode_writes = 0;
    int fail_count  = 0;

    upc_pkg::upc_out_t want_code;

    url_percent_codec_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .mode_we    (mode_we),
        .mode_wdata (mode_wdata),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_item  (byte_item),
        .code_valid (code_valid),
        .code_ready (code_ready),
        .code_item  (code_item)
    );

    always
    begin
        #(CLK_PERIOD / 2) clk = 1'b1;
        #(CLK_PERIOD / 2) clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Character classes
    // ------------------------------------------------------------------
    function automatic logic in_list(input string s, input logic [7:0] c);
        int i;
        for (i = 0; i < s.len(); i++)
            if (s[i] == c)
                return 1'b1;
        return 1'b0;
    endfunction

    // Characters an encode mode lets through untouched
    function automatic logic passes_plain(input logic [2:0] m, input logic [7:0] c);
        if ((c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z")
            || c == "-" || c == "." || c == upc_pkg::CH_UNDER)
            return 1'b1;
        if (m == upc_pkg::MODE_URI_ENC)
            return in_list("&!#$'()+,*/@?=;:~", c);
        if (m == upc_pkg::MODE_COMP_ENC)
            return in_list("!()*'~", c);
        return 1'b0;
    endfunction

    function automatic logic hex_ok(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
    endfunction

    // Only called on hex characters: letters of either case sit 9 above their low nibble
    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        return (c <= "9") ? c[3:0] : c[3:0] + 4'd9;
    endfunction

    function automatic logic [7:0] upper_hex(input logic [3:0] n);
        string digits;
        digits = "0123456789ABCDEF";
        return digits[n];
    endfunction

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    // Handle a byte with no escape pending: start an escape or pass it on
    task automatic decode_fresh(input logic [7:0] b, input logic form);
        if (b == upc_pkg::CH_PERCENT)
            dec_phase = upc_pkg::PH_PCT;
        else if (form && b == upc_pkg::CH_PLUS)
            burst.push_back(upc_pkg::CH_SPACE);
        else
            burst.push_back(b);
    endtask

    // Work out the coded bytes caused by one accepted item and queue them as due
    task automatic code_one_byte(input upc_pkg::upc_in_t it);
        logic [7:0]        b;
        logic              eos;
        logic              form;
        upc_pkg::upc_out_t code;
        b    = it.in_byte;
        eos  = it.end_of_string;
        form = (cur_mode == upc_pkg::MODE_FORM_DEC);
        burst.delete();
        if (cur_mode < upc_pkg::MODE_FORM_DEC)
        begin
            if (cur_mode == upc_pkg::MODE_FORM_ENC && b == upc_pkg::CH_SPACE)
                burst.push_back(upc_pkg::CH_PLUS);
            else if (passes_plain(cur_mode, b))
                burst.push_back(b);
            else
            begin
                burst.push_back(upc_pkg::CH_PERCENT);
                burst.push_back(upper_hex(b[7:4]));
                burst.push_back(upper_hex(b[3:0]));
            end
            if (eos)
            begin
                dec_phase = upc_pkg::PH_IDLE;
                held_char = 8'd0;
            end
        end
        else
        begin
            // Modes above plain decode fall in here too and decode without '+'
            case (dec_phase)
                upc_pkg::PH_PCT:
                begin
                    if (hex_ok(b))
                    begin
                        held_char = b;
                        dec_phase = upc_pkg::PH_DIGIT;
                    end
                    else
                    begin
                        burst.push_back(upc_pkg::CH_PERCENT);
                        dec_phase = upc_pkg::PH_IDLE;
                        decode_fresh(b, form);
                    end
                end
                upc_pkg::PH_DIGIT:
                begin
                    if (hex_ok(b))
                        burst.push_back({nibble_of(held_char), nibble_of(b)});
                    else
                    begin
                        burst.push_back(upc_pkg::CH_PERCENT);
                        burst.push_back(held_char);
                    end
                    dec_phase = upc_pkg::PH_IDLE;
                    held_char = 8'd0;
                    if (!hex_ok(b))
                        decode_fresh(b, form);
                end
                default:
                begin
                    dec_phase = upc_pkg::PH_IDLE;
                    decode_fresh(b, form);
                end
            endcase
            // Flush whatever escape is still held at the end of the string
            if (eos)
            begin
                if (dec_phase != upc_pkg::PH_IDLE)
                    burst.push_back(upc_pkg::CH_PERCENT);
                if (dec_phase == upc_pkg::PH_DIGIT)
                    burst.push_back(held_char);
                dec_phase = upc_pkg::PH_IDLE;
                held_char = 8'd0;
            end
        end
        foreach (burst[i])
        begin
            code.out_byte      = burst[i];
            code.last_of_run   = (i == burst.size() - 1);
            code.string_done   = (i == burst.size() - 1) && eos;
            due_codes.push_back(code);
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: offer queued items, hold each one until it is taken
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid <= 1'b0;
            byte_item  <= '0;
        end
        else
        begin
            if (byte_valid && byte_ready)
            begin
                code_one_byte(byte_item);
                bytes_taken++;
            end
            // Advance only when the slot is empty or its item was just taken
            if (!byte_valid || byte_ready)
            begin
                if (byte_feed.size() != 0 && (steady || $urandom_range(99) >= 30))
                begin
                    byte_item  <= byte_feed.pop_front();
                    byte_valid <= 1'b1;
                end
                else
                    byte_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each taken item, drive ready with random and long stalls
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            code_ready <= 1'b0;
        else
        begin
            if (code_valid && code_ready)
            begin
                codes_seen++;
                if (due_codes.size() == 0)
                begin
                    $error("output item %h with nothing due", code_item.out_byte);
                    fail_count++;
                end
                else
                begin
                    want_code = due_codes.pop_front();
                    if (code_item.out_byte !== want_code.out_byte)
                    begin
                        $error("out_byte: expected %h, got %h",
                               want_code.out_byte, code_item.out_byte);
                        fail_count++;
                    end
                    if (code_item.last_of_run !== want_code.last_of_run)
                    begin
                        $error("last_of_run: expected %b, got %b",
                               want_code.last_of_run, code_item.last_of_run);
                        fail_count++;
                    end
                    if (code_item.string_done !== want_code.string_done)
                    begin
                        $error("string_done: expected %b, got %b",
                               want_code.string_done, code_item.string_done);
                        fail_count++;
                    end
                end
            end
            // Hold off once for a long stretch so the block backs up into its input
            if (hold_request && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = 200;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                code_ready <= 1'b0;
            end
            else
                code_ready <= steady || ($urandom_range(99) >= 30);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_byte(input logic [7:0] b, input logic eos);
        upc_pkg::upc_in_t it;
        it.in_byte       = b;
        it.end_of_string = eos;
        byte_feed.push_back(it);
    endtask

    function automatic logic rand_eos();
        return $urandom_range(7) == 0;
    endfunction

    // Mix of arbitrary bytes, printable text, URL marks and alphanumerics
    function automatic logic [7:0] rand_text_byte();
        string marks;
        string alnum;
        marks = " -._~&!#$'()+,*/@?=;:%";
        alnum = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";
        case ($urandom_range(3))
            0:       return 8'($urandom_range(255));
            1:       return 8'($urandom_range(126, 32));
            2:       return marks[$urandom_range(marks.len() - 1)];
            default: return alnum[$urandom_range(alnum.len() - 1)];
        endcase
    endfunction

    function automatic logic [7:0] rand_hex_char();
        string digits;
        digits = "0123456789ABCDEFabcdef";
        return digits[$urandom_range(digits.len() - 1)];
    endfunction

    function automatic logic [7:0] rand_non_hex();
        logic [7:0] c;
        do
            c = 8'($urandom_range(255));
        while (hex_ok(c));
        return c;
    endfunction

    // Well-formed escapes with random digits in 45 of 100 picks; the rest is plain text,
    // plus signs and broken or truncated escapes
    task automatic queue_decode_chunk(output int n);
        int pick;
        pick = $urandom_range(99);
        if (pick < 45)
        begin
            queue_byte(upc_pkg::CH_PERCENT, 1'b0);
            queue_byte(rand_hex_char(), 1'b0);
            queue_byte(rand_hex_char(), rand_eos());
            n = 3;
        end
        else if (pick < 70)
        begin
            queue_byte(rand_text_byte(), rand_eos());
            n = 1;
        end
        else if (pick < 80)
        begin
            queue_byte(upc_pkg::CH_PLUS, rand_eos());
            n = 1;
        end
        else if (pick < 90)
        begin
            queue_byte(upc_pkg::CH_PERCENT, 1'b0);
            queue_byte(rand_non_hex(), rand_eos());
            n = 2;
        end
        else if (pick < 95)
        begin
            queue_byte(upc_pkg::CH_PERCENT, 1'b0);
            queue_byte(rand_hex_char(), 1'b0);
            queue_byte(rand_non_hex(), rand_eos());
            n = 3;
        end
        else if ($urandom_range(1) == 1)
        begin
            queue_byte(upc_pkg::CH_PERCENT, 1'b0);
            queue_byte(rand_hex_char(), 1'b1);
            n = 2;
        end
        else
        begin
            queue_byte(upc_pkg::CH_PERCENT, 1'b1);
            n = 1;
        end
    endtask

    task automatic run_random(input int count);
        int queued;
        int n;
        queued = 0;
        while (queued < count)
        begin
            if (cur_mode < upc_pkg::MODE_FORM_DEC)
            begin
                queue_byte(rand_text_byte(), rand_eos());
                n = 1;
            end
            else
                queue_decode_chunk(n);
            queued += n;
        end
    endtask

    // Wait until every item is taken and every due output has arrived, then let
    // an item that produced nothing settle before the next mode write
    task automatic drain();
        int waited;
        waited = 0;
        while (byte_feed.size() != 0 || byte_valid)
            @(posedge clk);
        while (due_codes.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        if (due_codes.size() != 0)
        begin
            $error("%0d expected output items never arrived", due_codes.size());
            fail_count++;
            due_codes.delete();
        end
        repeat (10) @(posedge clk);
    endtask

    // One-cycle write pulse; the write also drops any pending escape
    task automatic set_mode(input logic [2:0] m);
        @(posedge clk);
        mode_we    <= 1'b1;
        mode_wdata <= m;
        @(posedge clk);
        mode_we   <= 1'b0;
        cur_mode  = m;
        dec_phase = upc_pkg::PH_IDLE;
        held_char = 8'd0;
        mode_writes++;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Form encode straight out of reset: space, tilde and both byte extremes
        queue_byte(upc_pkg::CH_SPACE, 1'b0);
        queue_byte(upc_pkg::CH_TILDE, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b1);
        run_random(30);
        drain();

        // URI encode keeps the reserved marks
        set_mode(upc_pkg::MODE_URI_ENC);
        queue_byte(upc_pkg::CH_TILDE, 1'b0);
        queue_byte("&", 1'b0);
        queue_byte(8'h7F, 1'b1);
        run_random(30);
        drain();

        set_mode(upc_pkg::MODE_COMP_ENC);
        queue_byte("!", 1'b0);
        queue_byte("#", 1'b1);
        run_random(30);
        drain();

        // Form decode: good escape, plus, a percent breaking an escape and
        // restarting one, a bad second digit, and a flush at end of string
        set_mode(upc_pkg::MODE_FORM_DEC);
        queue_byte(upc_pkg::CH_PERCENT, 1'b0);
        queue_byte("4", 1'b0);
        queue_byte("a", 1'b0);
        queue_byte(upc_pkg::CH_PLUS, 1'b0);
        queue_byte(upc_pkg::CH_PERCENT, 1'b0);
        queue_byte(upc_pkg::CH_PERCENT, 1'b0);
        queue_byte("G", 1'b0);
        queue_byte(upc_pkg::CH_PERCENT, 1'b0);
        queue_byte("4", 1'b0);
        queue_byte("Z", 1'b0);
        queue_byte(upc_pkg::CH_PERCENT, 1'b0);
        queue_byte("4", 1'b1);
        // Stall the receiver while this phase keeps offering items
        hold_request <= 1'b1;
        run_random(60);
        drain();

        // Plain decode without any idling; leave an escape pending for the write
        steady <= 1'b1;
        set_mode(upc_pkg::MODE_DEC);
        queue_byte(upc_pkg::CH_PLUS, 1'b0);
        queue_byte(upc_pkg::CH_PERCENT, 1'b1);
        run_random(60);
        queue_byte(upc_pkg::CH_PERCENT, 1'b0);
        queue_byte("7", 1'b0);
        drain();
        steady <= 1'b0;

        // Unused mode codes decode like plain decode
        set_mode(3'd5);
        run_random(20);
        drain();
        set_mode(3'd6);
        run_random(15);
        drain();
        set_mode(3'd7);
        run_random(20);
        drain();

        set_mode(upc_pkg::MODE_FORM_ENC);
        run_random(30);
        drain();
        set_mode(upc_pkg::MODE_FORM_DEC);
        run_random(35);
        drain();

        repeat (20) @(posedge clk);
        $display("Covered %0d input items and %0d output items over %0d mode writes,",
                 bytes_taken, codes_seen, mode_writes);
        $display("all three encode rules, both decode rules and the unused mode codes.");
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog far beyond the slowest legal run
    initial
    begin
        #(CLK_PERIOD * 300000);
        $display("Test completed with failures");
        $finish;
    end

endmodule
